/* design/ptc_pkg.sv */
// Package for the point-in-triangle classifier: result codes, the flag group
// passed between the last pipeline stages and the operand tables of the dot products.
// No dependencies.
package ptc_pkg;

	localparam int TOL_W = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

	typedef enum logic [2:0] {
		POS_OUTSIDE    = 3'd0,
		POS_INSIDE     = 3'd1,
		POS_EDGE       = 3'd2,
		POS_VERTEX     = 3'd3,
		POS_DEGENERATE = 3'd4
	} position_t;

	// outcome of the zero-determinant check and the tolerance comparisons, one bit per test
	typedef struct packed {
		logic degen;
		logic outside;
		logic near_u1;
		logic near_v1;
		logic near_u0;
		logic near_v0;
		logic near_sum;
	} flags_t;

	// edge vectors: 0 = C-A, 1 = B-A, 2 = P-A
	// dot products: 0 = d00, 1 = d01, 2 = d02, 3 = d11, 4 = d12
	localparam logic [1:0] DOT_L [5] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1};
	localparam logic [1:0] DOT_R [5] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2};

	// wide products: d00*d11, d01*d01, d11*d02, d01*d12, d00*d12, d01*d02
	localparam logic [2:0] BIG_A [6] = '{3'd0, 3'd1, 3'd3, 3'd1, 3'd0, 3'd1};
	localparam logic [2:0] BIG_B [6] = '{3'd3, 3'd1, 3'd2, 3'd4, 3'd4, 3'd2};

endpackage

/* design/ptc_query_if.sv */
// Query channel: triangle vertices A, B, C and point P with valid/ready.
// No dependencies.
interface ptc_query_if #(
	parameter int COORD_BITS = 16
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_x, a_y, a_z;
	logic signed [COORD_BITS-1:0] b_x, b_y, b_z;
	logic signed [COORD_BITS-1:0] c_x, c_y, c_z;
	logic signed [COORD_BITS-1:0] p_x, p_y, p_z;

	modport source (
		output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z,
		input  ready
	);
	modport sink (
		input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z,
		output ready
	);
endinterface

/* design/ptc_result_if.sv */
// Result channel: classification code with valid/ready.
// Depends on ptc_pkg.
interface ptc_result_if
	import ptc_pkg::*;
();
	logic      valid;
	logic      ready;
	position_t position;

	modport source (output valid, position, input ready);
	modport sink (input valid, position, output ready);
endinterface

/* design/ptc_cfg_if.sv */
// Configuration write channel: tolerance register data with valid/ready.
// Depends on ptc_pkg.
interface ptc_cfg_if
	import ptc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [TOL_W-1:0] tolerance_q16;

	modport source (output valid, tolerance_q16, input ready);
	modport sink (input valid, tolerance_q16, output ready);
endinterface

/* design/point_in_triangle_classifier.sv */
// Barycentric point-in-triangle classifier. Takes one request per cycle and
// returns one position code per request, in order, after these stages: edge
// vectors, their products, the five dot products, the partial products of the
// six wide products, their assembly, the determinant d and numerators nu and
// nv, the tolerance product split over two stages, the comparisons and the
// output register. The rate is one request per cycle; when the result is not
// taken the whole pipeline holds, so nothing is lost or repeated. No division
// is done: nu, nv and d are scaled by 2^TOL_FRAC_BITS and compared exactly
// against tolerance_q16 * d. Write the tolerance only while the block is idle.
// Depends on ptc_pkg, ptc_query_if, ptc_result_if and ptc_cfg_if.
module point_in_triangle_classifier
	import ptc_pkg::*;
#(
	parameter int COORD_BITS    = 16,
	parameter int TOL_FRAC_BITS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	ptc_query_if.sink   query,
	ptc_result_if.source result,
	ptc_cfg_if.sink     cfg
);

	// widths through the pipeline
	localparam int VW   = COORD_BITS + 1;       // edge vector component
	localparam int PW1  = 2 * VW;               // component product
	localparam int DW   = PW1 + 2;              // dot product
	localparam int H    = (DW + 1) / 2;         // low half of a dot product
	localparam int HW   = DW - H;               // signed high half
	localparam int LLW  = 2 * H;
	localparam int XW   = H + 1 + HW;           // low by high cross product
	localparam int MW   = XW + 1;               // sum of the cross products
	localparam int HHW  = 2 * HW;
	localparam int PW   = 2 * DW;               // wide product
	localparam int NW   = PW + 1;               // d, nu, nv
	localparam int NW1  = NW + 1;
	localparam int NW2  = NW + 2;
	localparam int DL   = NW / 2;               // low slice of d for the tolerance product
	localparam int DH   = NW - DL;
	localparam int EW   = TOL_W + NW;
	localparam int CW   = NW + 3 + ((TOL_FRAC_BITS > TOL_W) ? TOL_FRAC_BITS : TOL_W);
	localparam int NSTAGE = 11;

	// control
	logic [NSTAGE-1:0] stage_vld_q;
	logic [TOL_W-1:0]  tol_q;
	logic              advance;

	// advance the whole pipeline unless a finished result is held back
	assign advance      = !stage_vld_q[NSTAGE-1] || result.ready;
	assign query.ready  = advance;
	assign result.valid = stage_vld_q[NSTAGE-1];
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
			tol_q       <= TOL_RESET;
		end else begin
			if (advance) begin
				stage_vld_q <= {stage_vld_q[NSTAGE-2:0], query.valid};
			end
			if (cfg.valid) begin
				tol_q <= cfg.tolerance_q16;
			end
		end
	end

	// vertex inputs as arrays by axis
	logic signed [COORD_BITS-1:0] va [3], vb [3], vc [3], vp [3];
	assign va = '{query.a_x, query.a_y, query.a_z};
	assign vb = '{query.b_x, query.b_y, query.b_z};
	assign vc = '{query.c_x, query.c_y, query.c_z};
	assign vp = '{query.p_x, query.p_y, query.p_z};

	// pipeline payload
	logic signed [VW-1:0]  vec_s1  [3][3];          // [vector][axis]
	logic signed [PW1-1:0] prod_s2 [5][3];          // [dot][axis]
	logic signed [DW-1:0]  dot_s3  [5];
	logic        [LLW-1:0] ll_s4   [6];
	logic signed [XW-1:0]  lh_s4   [6];
	logic signed [XW-1:0]  hl_s4   [6];
	logic signed [HHW-1:0] hh_s4   [6];
	logic signed [PW-1:0]  cat_s5  [6];
	logic signed [MW-1:0]  mid_s5  [6];
	logic signed [PW-1:0]  big_s6  [6];
	logic signed [NW-1:0]  d_s7, nu_s7, nv_s7;
	logic [TOL_W+DL-1:0]   elo_s8;
	logic [TOL_W+DH-1:0]   ehi_s8;
	logic signed [NW-1:0]  d_s8, nu_s8, nv_s8;
	logic signed [NW1-1:0] nab_s8, umd_s8, vmd_s8;
	logic                  degen_s8, degen_s9;
	logic [EW-1:0]         e_s9;
	logic signed [NW-1:0]  nu_s9, nv_s9;
	logic signed [NW1-1:0] umd_s9, vmd_s9;
	logic signed [NW2-1:0] abd_s9;
	flags_t                flags_s10;
	position_t             position_q;

	// stage 10 comparison operands, numerators scaled by 2^TOL_FRAC_BITS
	logic signed [CW-1:0] su, sv, sumd, sud, svd, ew;
	assign su   = CW'(nu_s9)  <<< TOL_FRAC_BITS;
	assign sv   = CW'(nv_s9)  <<< TOL_FRAC_BITS;
	assign sumd = CW'(abd_s9) <<< TOL_FRAC_BITS;
	assign sud  = CW'(umd_s9) <<< TOL_FRAC_BITS;
	assign svd  = CW'(vmd_s9) <<< TOL_FRAC_BITS;
	assign ew   = signed'(CW'(e_s9));

	function automatic logic within_tol(input logic signed [CW-1:0] x,
	                                    input logic signed [CW-1:0] e);
		return (x <= e) && (x >= -e);
	endfunction

	flags_t flags_d;
	always_comb begin
		flags_d.degen    = degen_s9;
		flags_d.outside  = (su < -ew) || (sv < -ew) || (sumd > ew);
		flags_d.near_u1  = within_tol(sud, ew);
		flags_d.near_v1  = within_tol(svd, ew);
		flags_d.near_u0  = within_tol(su, ew);
		flags_d.near_v0  = within_tol(sv, ew);
		flags_d.near_sum = within_tol(sumd, ew);
	end

	position_t position_d;
	always_comb begin
		priority if (flags_s10.degen) begin
			position_d = POS_DEGENERATE;
		end else if (flags_s10.outside) begin
			position_d = POS_OUTSIDE;
		end else if (flags_s10.near_u1 || flags_s10.near_v1 ||
		             (flags_s10.near_u0 && flags_s10.near_v0)) begin
			position_d = POS_VERTEX;
		end else if (flags_s10.near_sum || flags_s10.near_u0 || flags_s10.near_v0) begin
			position_d = POS_EDGE;
		end else begin
			position_d = POS_INSIDE;
		end
	end

	assign result.position = position_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			// stage 1: edge vectors from vertex A
			for (int k = 0; k < 3; k++) begin
				vec_s1[0][k] <= VW'(vc[k]) - VW'(va[k]);
				vec_s1[1][k] <= VW'(vb[k]) - VW'(va[k]);
				vec_s1[2][k] <= VW'(vp[k]) - VW'(va[k]);
			end
			// stage 2: component products
			for (int i = 0; i < 5; i++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[i][k] <= PW1'(vec_s1[DOT_L[i]][k]) * PW1'(vec_s1[DOT_R[i]][k]);
				end
			end
			// stage 3: dot products
			for (int i = 0; i < 5; i++) begin
				dot_s3[i] <= DW'(prod_s2[i][0]) + DW'(prod_s2[i][1]) + DW'(prod_s2[i][2]);
			end
			// stage 4: split each wide product into half-width partial products
			for (int i = 0; i < 6; i++) begin
				ll_s4[i] <= LLW'(dot_s3[BIG_A[i]][H-1:0]) * LLW'(dot_s3[BIG_B[i]][H-1:0]);
				lh_s4[i] <= XW'(signed'({1'b0, dot_s3[BIG_A[i]][H-1:0]}))
				          * XW'(signed'(dot_s3[BIG_B[i]][DW-1:H]));
				hl_s4[i] <= XW'(signed'(dot_s3[BIG_A[i]][DW-1:H]))
				          * XW'(signed'({1'b0, dot_s3[BIG_B[i]][H-1:0]}));
				hh_s4[i] <= HHW'(signed'(dot_s3[BIG_A[i]][DW-1:H]))
				          * HHW'(signed'(dot_s3[BIG_B[i]][DW-1:H]));
			end
			// stage 5: outer partials do not overlap, join them; sum the cross terms
			for (int i = 0; i < 6; i++) begin
				cat_s5[i] <= signed'({hh_s4[i], ll_s4[i]});
				mid_s5[i] <= MW'(lh_s4[i]) + MW'(hl_s4[i]);
			end
			// stage 6: full products
			for (int i = 0; i < 6; i++) begin
				big_s6[i] <= cat_s5[i] + (PW'(mid_s5[i]) <<< H);
			end
			// stage 7: determinant and numerators
			d_s7  <= NW'(big_s6[0]) - NW'(big_s6[1]);
			nu_s7 <= NW'(big_s6[2]) - NW'(big_s6[3]);
			nv_s7 <= NW'(big_s6[4]) - NW'(big_s6[5]);
			// stage 8: tolerance product in two slices of d (d is never negative)
			elo_s8   <= (TOL_W+DL)'(tol_q) * (TOL_W+DL)'(d_s7[DL-1:0]);
			ehi_s8   <= (TOL_W+DH)'(tol_q) * (TOL_W+DH)'(d_s7[NW-1:DL]);
			d_s8     <= d_s7;
			nu_s8    <= nu_s7;
			nv_s8    <= nv_s7;
			nab_s8   <= NW1'(nu_s7) + NW1'(nv_s7);
			umd_s8   <= NW1'(nu_s7) - NW1'(d_s7);
			vmd_s8   <= NW1'(nv_s7) - NW1'(d_s7);
			degen_s8 <= (d_s7 == '0);
			// stage 9: join the tolerance slices, form u + v - 1
			e_s9     <= EW'(elo_s8) + (EW'(ehi_s8) << DL);
			abd_s9   <= NW2'(nab_s8) - NW2'(d_s8);
			nu_s9    <= nu_s8;
			nv_s9    <= nv_s8;
			umd_s9   <= umd_s8;
			vmd_s9   <= vmd_s8;
			degen_s9 <= degen_s8;
			// stage 10: tolerance comparisons
			flags_s10 <= flags_d;
			// output register
			position_q <= position_d;
		end
	end

endmodule

/* sim/point_in_triangle_classifier_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for point_in_triangle_classifier: directed and random requests,
// a barycentric classifier predicting each position code, and random stalls on both sides.
// Depends on ptc_pkg, ptc_query_if, ptc_result_if, ptc_cfg_if and the classifier itself.
module point_in_triangle_classifier_tb;
	import ptc_pkg::*;

	localparam int COORD_W      = 16;
	localparam int FRAC_W       = 16;
	localparam int PIPE_LATENCY = 11;
	localparam int STALL_LIMIT  = 500;

	// coordinate slots in a request: vertex A, B, C, then the point, x y z each
	localparam int A_IDX = 0;
	localparam int B_IDX = 3;
	localparam int C_IDX = 6;
	localparam int P_IDX = 9;

	typedef logic [11:0][COORD_W-1:0] query_t;
	// wide enough for d, nu and nv scaled by 2^16 with plenty of headroom
	typedef logic signed [191:0] wide_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic [TOL_W-1:0] tolerance_setting = TOL_RESET;
	position_t        pending_positions[$];
	position_t        oldest_position;
	int               error_count = 0;
	int               idle_cycles = 0;
	bit               burst_mode = 1'b0;

	ptc_query_if #(.COORD_BITS(COORD_W)) query_ch ();
	ptc_result_if result_ch ();
	ptc_cfg_if cfg_ch ();

	point_in_triangle_classifier #(
		.COORD_BITS   (COORD_W),
		.TOL_FRAC_BITS(FRAC_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.query (query_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Closeness on the scaled grid: |x - t| <= e.
	function automatic bit is_close(wide_t x, wide_t t, wide_t e);
		wide_t diff;
		diff = x - t;
		return (diff <= e) && (-diff <= e);
	endfunction

	// Barycentric classification in exact integer form. u = nu/d and v = nv/d are never
	// formed; instead nu, nv and d are scaled by 2^16 and compared against tol * d.
	function automatic position_t classify_point(query_t q, logic [TOL_W-1:0] tol);
		wide_t ca[3], ba[3], pa[3];
		wide_t d00, d01, d02, d11, d12;
		wide_t det, nu, nv, su, sv, sd, e, total;
		bit    at_u0, at_v0;
		int    k;
		d00 = 0; d01 = 0; d02 = 0; d11 = 0; d12 = 0;
		for (k = 0; k < 3; k++) begin
			ca[k] = wide_t'($signed(q[C_IDX+k])) - wide_t'($signed(q[A_IDX+k]));
			ba[k] = wide_t'($signed(q[B_IDX+k])) - wide_t'($signed(q[A_IDX+k]));
			pa[k] = wide_t'($signed(q[P_IDX+k])) - wide_t'($signed(q[A_IDX+k]));
			d00 += ca[k] * ca[k];
			d01 += ca[k] * ba[k];
			d02 += ca[k] * pa[k];
			d11 += ba[k] * ba[k];
			d12 += ba[k] * pa[k];
		end
		det = d00 * d11 - d01 * d01;
		if (det == 0)
			return POS_DEGENERATE;
		nu = d11 * d02 - d01 * d12;
		nv = d00 * d12 - d01 * d02;
		su = nu <<< FRAC_W;
		sv = nv <<< FRAC_W;
		sd = det <<< FRAC_W;
		e = det * wide_t'(tol);
		total = su + sv;
		// region test first: u >= -T, v >= -T, u + v <= 1 + T
		if ((su + e < 0) || (sv + e < 0) || (total > sd + e))
			return POS_OUTSIDE;
		at_u0 = is_close(su, 0, e);
		at_v0 = is_close(sv, 0, e);
		// vertex C (u = 1), vertex B (v = 1) or vertex A (both zero) win over the edges
		if (is_close(su, sd, e) || is_close(sv, sd, e) || (at_u0 && at_v0))
			return POS_VERTEX;
		if (is_close(total, sd, e) || at_u0 || at_v0)
			return POS_EDGE;
		return POS_INSIDE;
	endfunction

	function automatic query_t make_query(int ax, int ay, int az, int bx, int by, int bz,
		int cx, int cy, int cz, int px, int py, int pz);
		query_t q;
		q[A_IDX] = COORD_W'(ax); q[A_IDX+1] = COORD_W'(ay); q[A_IDX+2] = COORD_W'(az);
		q[B_IDX] = COORD_W'(bx); q[B_IDX+1] = COORD_W'(by); q[B_IDX+2] = COORD_W'(bz);
		q[C_IDX] = COORD_W'(cx); q[C_IDX+1] = COORD_W'(cy); q[C_IDX+2] = COORD_W'(cz);
		q[P_IDX] = COORD_W'(px); q[P_IDX+1] = COORD_W'(py); q[P_IDX+2] = COORD_W'(pz);
		return q;
	endfunction

	// Symmetric draw in [-lim, lim].
	function automatic int draw_signed(int lim);
		return int'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// Send one request: idle for a random gap, present it, hold until accepted, then
	// record the position it must produce. Valid is left high on return so that a
	// back-to-back request never drops it between items.
	task automatic send_query(query_t q);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			query_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		{query_ch.p_z, query_ch.p_y, query_ch.p_x, query_ch.c_z, query_ch.c_y, query_ch.c_x,
			query_ch.b_z, query_ch.b_y, query_ch.b_x, query_ch.a_z, query_ch.a_y,
			query_ch.a_x} <= q;
		query_ch.valid <= 1'b1;
		do @(posedge clk); while (!query_ch.ready);
		pending_positions.push_back(classify_point(q, tolerance_setting));
	endtask

	// Reference triangle lying in a plane parallel to z = 0: u runs along x and v along
	// y, both in steps of 1/1000. The point is given relative to vertex A.
	task automatic send_ref_point(int x, int y, int z);
		send_query(make_query(-300, 200, 50, -300, 1200, 50, 700, 200, 50,
			-300 + x, 200 + y, 50 + z));
	endtask

	// Drop the request line and let the pipeline run dry, then allow its latency again.
	task automatic drain_pipeline();
		@(negedge clk);
		query_ch.valid <= 1'b0;
		while (pending_positions.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	// Only write the tolerance with the pipeline empty.
	task automatic write_tolerance(logic [TOL_W-1:0] value);
		drain_pipeline();
		@(negedge clk);
		cfg_ch.tolerance_q16 <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		tolerance_setting = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Zero Gram determinant: coincident vertices, collinear vertices, full-scale extremes.
	task automatic test_degenerate_triangles();
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(make_query(0, 0, 0, 100, 200, 300, -50, -100, -150, 7, 8, 9));
		send_query(make_query(1, 2, 3, 40, -5, 7, 40, -5, 7, 40, -5, 7));
		send_query(make_query(-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, -32768, -32768, 32767, 32767, 32767));
	endtask

	// Each vertex, each edge, and points one or two tolerance steps off an edge.
	task automatic test_vertices_and_edges();
		send_ref_point(0, 0, 0);
		send_ref_point(1000, 0, 0);
		send_ref_point(0, 1000, 0);
		send_ref_point(500, 500, 0);
		send_ref_point(0, 400, 0);
		send_ref_point(600, 0, 0);
		// u = 0.001 and u = -0.001 fall inside the reset tolerance, u = 0.002 does not
		send_ref_point(1, 500, 0);
		send_ref_point(-1, 500, 0);
		send_ref_point(2, 500, 0);
	endtask

	// Plain interior and exterior points, a point off the plane, and a full-scale triangle.
	task automatic test_inside_outside();
		send_ref_point(200, 300, 0);
		send_ref_point(250, 250, 4000);
		send_ref_point(-10, 500, 0);
		send_ref_point(500, -10, 0);
		send_ref_point(600, 600, 0);
		send_query(make_query(-32768, -32768, -32768, 32767, -32768, 32767,
			32767, 32767, -32768, 0, 0, 0));
	endtask

	// Zero tolerance makes every test exact; the largest one (almost 1) stretches the
	// region and pulls most points onto a vertex, since the vertex tests come first.
	task automatic test_tolerance_extremes();
		write_tolerance(16'd0);
		send_ref_point(1, 500, 0);
		send_ref_point(-1, 500, 0);
		send_ref_point(500, 500, 0);
		write_tolerance(16'hFFFF);
		send_ref_point(200, 300, 0);
		send_ref_point(-500, 600, 0);
		send_ref_point(1500, -200, 0);
	endtask

	// Random requests over several tolerance settings. Most are built on a lattice so that
	// u and v land exactly on 0, 1 and the hypotenuse; some are nudged off the lattice,
	// some are degenerate, and the rest are raw full-range noise.
	task automatic test_random_queries();
		logic [TOL_W-1:0] settings[6];
		query_t           q;
		int               base[3], e0[3], e1[3];
		int               phase, n, i, kind, k, lim, s, t, mul_b, mul_c;
		settings = '{16'd66, 16'd1, 16'd32768, 16'd0, 16'hFFFF, 16'd700};
		settings[5] = $urandom_range(1, 2000);
		for (phase = 0; phase < 6; phase++) begin
			write_tolerance(settings[phase]);
			burst_mode = (phase % 3 == 2);
			for (n = 0; n < 250; n++) begin
				kind = $urandom_range(0, 19);
				k = $urandom_range(1, 8);
				lim = $urandom_range(1, 12000 / (k + 1));
				for (i = 0; i < 3; i++) begin
					base[i] = draw_signed(8000);
					e0[i] = draw_signed(lim);
					e1[i] = draw_signed(lim);
				end
				if (kind < 3) begin
					for (i = 0; i < 12; i++)
						q[i] = COORD_W'($urandom);
				end else if (kind < 5) begin
					// both edges along one direction, possibly with coincident vertices
					mul_b = $urandom_range(0, k);
					mul_c = $urandom_range(0, k);
					for (i = 0; i < 3; i++) begin
						q[A_IDX+i] = COORD_W'(base[i]);
						q[B_IDX+i] = COORD_W'(base[i] + mul_b * e1[i]);
						q[C_IDX+i] = COORD_W'(base[i] + mul_c * e1[i]);
						q[P_IDX+i] = COORD_W'(draw_signed(32000));
					end
				end else begin
					// u = s/k and v = t/k, each from -1/k to (k+1)/k
					s = int'($urandom_range(0, k + 2)) - 1;
					t = int'($urandom_range(0, k + 2)) - 1;
					for (i = 0; i < 3; i++) begin
						q[A_IDX+i] = COORD_W'(base[i]);
						q[B_IDX+i] = COORD_W'(base[i] + k * e1[i]);
						q[C_IDX+i] = COORD_W'(base[i] + k * e0[i]);
						q[P_IDX+i] = COORD_W'(base[i] + s * e0[i] + t * e1[i]
							+ ((kind < 8) ? draw_signed(3) : 0));
					end
				end
				send_query(q);
			end
		end
		burst_mode = 1'b0;
	endtask

	// Result side: stall a random number of cycles before each result, then hold ready.
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = burst_mode ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(arst_n && result_ch.valid));
		end
	end

	// Compare each accepted result with the oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_positions.size() == 0) begin
				$display("%0t: unexpected result: expected none, got position %0d",
					$time, result_ch.position);
				error_count++;
			end else begin
				oldest_position = pending_positions.pop_front();
				if (result_ch.position !== oldest_position) begin
					$display("%0t: position mismatch: expected %0d, got %0d",
						$time, oldest_position, result_ch.position);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run if no request, result or register write moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		// hold every input at a known value through reset
		arst_n = 1'b0;
		query_ch.valid = 1'b0;
		{query_ch.p_z, query_ch.p_y, query_ch.p_x, query_ch.c_z, query_ch.c_y, query_ch.c_x,
			query_ch.b_z, query_ch.b_y, query_ch.b_x, query_ch.a_z, query_ch.a_y,
			query_ch.a_x} = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.tolerance_q16 = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// the first three run on the tolerance left by reset
		test_degenerate_triangles();
		test_vertices_and_edges();
		test_inside_outside();
		test_tolerance_extremes();
		test_random_queries();

		drain_pipeline();
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
